// ===== rtl/rtri_pkg.sv =====
// ----------------------------------------------------------------------------
// rtri_pkg
// Shared constants, command and status codes, and transaction payload types
// for the triangle rasterizer with depth test.
// ----------------------------------------------------------------------------
package rtri_pkg;

    // screen geometry and subpixel precision
    localparam int FB_WIDTH  = 128;
    localparam int FB_HEIGHT = 128;
    localparam int SUB_BITS  = 4;
    localparam int NPIX      = FB_WIDTH * FB_HEIGHT;
    localparam int ADDR_W    = $clog2(NPIX);
    localparam int XW        = $clog2(FB_WIDTH);
    localparam int YW        = $clog2(FB_HEIGHT);

    // setup arithmetic widths
    localparam int MA_W       = 40;
    localparam int MB_W       = 32;
    localparam int PROD_W     = 72;
    localparam int DEN_W      = 36;
    localparam int Q_W        = 32;
    localparam int DIGIT_W    = 8;
    localparam int MUL_DIGITS = MA_W / DIGIT_W;

    // commands
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // result status
    localparam logic [1:0] RES_DONE      = 2'd0;
    localparam logic [1:0] RES_DRAWN     = 2'd1;
    localparam logic [1:0] RES_CULLED    = 2'd2;
    localparam logic [1:0] RES_OFFSCREEN = 2'd3;

    typedef struct packed {
        logic        [1:0]  cmd;
        logic signed [15:0] vertex_a_x;
        logic signed [15:0] vertex_a_y;
        logic signed [31:0] vertex_a_invw;
        logic signed [15:0] vertex_b_x;
        logic signed [15:0] vertex_b_y;
        logic signed [31:0] vertex_b_invw;
        logic signed [15:0] vertex_c_x;
        logic signed [15:0] vertex_c_y;
        logic signed [31:0] vertex_c_invw;
        logic        [31:0] color_value;
        logic        [13:0] pixel_index;
    } req_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic        [14:0] pixels_written;
        logic        [31:0] read_color;
        logic signed [31:0] read_depth;
    } rsp_t;

endpackage

// ===== rtl/rtri_if.sv =====
// ----------------------------------------------------------------------------
// rtri_if
// Valid/ready channels for command and result transactions.
// ----------------------------------------------------------------------------
interface rtri_req_if;
    logic          valid;
    logic          ready;
    rtri_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rtri_rsp_if;
    logic          valid;
    logic          ready;
    rtri_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rtri_ram.sv =====
// ----------------------------------------------------------------------------
// rtri_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rtri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/rtri_mul.sv =====
// ----------------------------------------------------------------------------
// rtri_mul
// Sequential signed multiplier, one 8-bit digit of the magnitude per cycle.
// ----------------------------------------------------------------------------
module rtri_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [rtri_pkg::MA_W-1:0]   a,
    input  logic signed [rtri_pkg::MB_W-1:0]   b,
    output logic                               done,
    output logic signed [rtri_pkg::PROD_W-1:0] p
);

    localparam int CNT_W = $clog2(rtri_pkg::MUL_DIGITS);

    logic                          busy_reg;
    logic                          fin_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [rtri_pkg::MA_W-1:0]     ma_reg;
    logic [rtri_pkg::MB_W-1:0]     mb_reg;
    logic                          neg_reg;
    logic [rtri_pkg::PROD_W-1:0]   acc_reg;
    logic [rtri_pkg::PROD_W-1:0]   p_reg;

    // digit sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(rtri_pkg::MUL_DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // magnitude shift-add, most significant digit first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a[rtri_pkg::MA_W-1] ? rtri_pkg::MA_W'(-a) : rtri_pkg::MA_W'(a);
            mb_reg  <= b[rtri_pkg::MB_W-1] ? rtri_pkg::MB_W'(-b) : rtri_pkg::MB_W'(b);
            neg_reg <= a[rtri_pkg::MA_W-1] ^ b[rtri_pkg::MB_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= (acc_reg << rtri_pkg::DIGIT_W)
                     + rtri_pkg::PROD_W'(mb_reg
                         * ma_reg[rtri_pkg::MA_W-1 -: rtri_pkg::DIGIT_W]);
            ma_reg  <= ma_reg << rtri_pkg::DIGIT_W;
        end
        else if (fin_reg)
        begin
            p_reg <= neg_reg ? -acc_reg : acc_reg;
        end
    end

    assign done = done_reg;
    assign p    = $signed(p_reg);

endmodule

// ===== rtl/rtri_div.sv =====
// ----------------------------------------------------------------------------
// rtri_div
// Restoring divider, signed numerator by positive denominator, quotient
// truncated toward zero and saturated to 32 bits, one bit per cycle.
// ----------------------------------------------------------------------------
module rtri_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [rtri_pkg::PROD_W-1:0] num,
    input  logic        [rtri_pkg::DEN_W-1:0]  den,
    output logic                               done,
    output logic signed [rtri_pkg::Q_W-1:0]    quo
);

    localparam int NW = rtri_pkg::PROD_W;
    localparam int QB = rtri_pkg::Q_W - 1;
    localparam int CW = $clog2(QB);

    localparam logic [1:0] P_IDLE  = 2'd0;
    localparam logic [1:0] P_CHECK = 2'd1;
    localparam logic [1:0] P_RUN   = 2'd2;
    localparam logic [1:0] P_FIN   = 2'd3;

    logic [1:0]    phase_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] dsh_reg;
    logic [QB-1:0] q_reg;
    logic          neg_reg;
    logic          sat_reg;
    logic signed [rtri_pkg::Q_W-1:0] quo_reg;
    logic          fits;

    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= P_CHECK;
                    end
                end
                P_CHECK:
                begin
                    cnt_reg   <= CW'(QB - 1);
                    phase_reg <= fits ? P_FIN : P_RUN;
                end
                P_RUN:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        phase_reg <= P_FIN;
                    end
                end
                P_FIN:
                begin
                    done_reg  <= 1'b1;
                    phase_reg <= P_IDLE;
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    // remainder and quotient datapath
    always_ff @(posedge clk)
    begin
        if (phase_reg == P_IDLE && start)
        begin
            neg_reg <= num[NW-1];
            rem_reg <= num[NW-1] ? NW'(-num) : NW'(num);
            dsh_reg <= NW'(den) << QB;
            q_reg   <= '0;
        end
        else if (phase_reg == P_CHECK)
        begin
            sat_reg <= fits;
            dsh_reg <= dsh_reg >> 1;
        end
        else if (phase_reg == P_RUN)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[QB-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
        else if (phase_reg == P_FIN)
        begin
            if (sat_reg)
            begin
                quo_reg <= neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
            end
            else
            begin
                quo_reg <= neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/triangle_raster_depth_test.sv =====
// ----------------------------------------------------------------------------
// triangle_raster_depth_test
// Flat shaded triangle rasterizer with a depth store and a colour store.
// ----------------------------------------------------------------------------
// Commands arrive as transactions on req and each gives exactly one result
// transaction on rsp. Clear fills the colour store with color_value and the
// depth store with far (0); it sweeps one entry per cycle. Read returns one
// pixel. Draw runs a setup of 17 products on a shared 8-bit-digit multiplier
// and three plane quotients on a one-bit-per-cycle divider, with the cull and
// walk setup, then walks the clipped bounding box at one pixel per cycle:
// each pixel reads the depth store, and the next cycle compares and writes
// depth and colour. A quotient that saturates skips the divider's bit loop;
// culled or off screen triangles end after the area product.
// One command is in flight at a time; req.ready is high while idle, so the
// next command is taken while a result still waits in the output register.
// When rsp stalls, a finished command holds until the output register
// frees. Reset clears the registers but not the stores; the stores hold
// nothing defined until the first clear.
// ----------------------------------------------------------------------------
module triangle_raster_depth_test (
    input  logic              clk,
    input  logic              rst_n,
    rtri_req_if.sink          req,
    rtri_rsp_if.source        rsp
);

    localparam int AW     = rtri_pkg::ADDR_W;
    localparam int XW     = rtri_pkg::XW;
    localparam int YW     = rtri_pkg::YW;
    localparam int SB     = rtri_pkg::SUB_BITS;
    localparam int ONE    = 1 << SB;
    localparam int PW     = rtri_pkg::PROD_W;
    localparam int MAW    = rtri_pkg::MA_W;
    localparam int MBW    = rtri_pkg::MB_W;
    localparam int EW     = MAW;
    localparam int CW     = 22;
    localparam int ZW     = 44;
    localparam int IXW    = ((AW > 14) ? AW : 14) + 1;

    localparam logic signed [PW-1:0] CULL_LIM = -PW'(ONE * ONE);
    localparam logic signed [CW-1:0] PX_HALF  = CW'(ONE / 2);
    localparam logic signed [16:0]   X_LIM    = 17'(rtri_pkg::FB_WIDTH - 1);
    localparam logic signed [16:0]   Y_LIM    = 17'(rtri_pkg::FB_HEIGHT - 1);
    localparam logic signed [ZW-1:0] Z_MAX    = ZW'(32'sh7FFFFFFF);
    localparam logic signed [ZW-1:0] Z_MIN    = ZW'(32'sh80000000);
    localparam logic [AW-1:0]        CLR_LAST = AW'(rtri_pkg::NPIX - 1);
    localparam logic [AW-1:0]        ROW_STEP = AW'(rtri_pkg::FB_WIDTH);

    // states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLEAR   = 4'd1;
    localparam logic [3:0] S_RDADDR  = 4'd2;
    localparam logic [3:0] S_RDDATA  = 4'd3;
    localparam logic [3:0] S_MULGO   = 4'd4;
    localparam logic [3:0] S_MULWAIT = 4'd5;
    localparam logic [3:0] S_CULL    = 4'd6;
    localparam logic [3:0] S_DIVGO   = 4'd7;
    localparam logic [3:0] S_DIVWAIT = 4'd8;
    localparam logic [3:0] S_PIXINIT = 4'd9;
    localparam logic [3:0] S_PIX     = 4'd10;
    localparam logic [3:0] S_DRAIN   = 4'd11;
    localparam logic [3:0] S_FIN     = 4'd12;

    // setup product sequence end points
    localparam logic [4:0] STEP_AREA_END = 5'd1;
    localparam logic [4:0] STEP_E0_END   = 5'd3;
    localparam logic [4:0] STEP_E1_END   = 5'd5;
    localparam logic [4:0] STEP_E2_END   = 5'd7;
    localparam logic [4:0] STEP_ZR_END   = 5'd10;
    localparam logic [4:0] STEP_ZX_END   = 5'd13;
    localparam logic [4:0] STEP_ZY_END   = 5'd16;

    logic [3:0]            state_reg;
    logic [4:0]            step_reg;
    rtri_pkg::req_t        item_reg;
    logic [1:0]            res_status_reg;
    logic [14:0]           count_reg;
    logic [31:0]           res_color_reg;
    logic [31:0]           res_depth_reg;
    logic                  rsp_valid_reg;
    rtri_pkg::rsp_t        rsp_data_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic signed [PW-1:0]  acc_reg;
    logic [rtri_pkg::DEN_W-1:0] den_reg;
    logic signed [EW-1:0]  e0_reg, e1_reg, e2_reg;
    logic signed [31:0]    zr_reg, zx_reg, zy_reg;
    logic [XW-1:0]         x0_reg, x1_reg, x_reg;
    logic [YW-1:0]         y0_reg, y1_reg, y_reg;
    logic signed [EW-1:0]  ecur0_reg, ecur1_reg, ecur2_reg;
    logic signed [EW-1:0]  erow0_reg, erow1_reg, erow2_reg;
    logic signed [ZW-1:0]  zcur_reg, zrow_reg;
    logic [AW-1:0]         row_addr_reg, pix_addr_reg;
    logic                  p1_valid_reg;
    logic [AW-1:0]         p1_addr_reg;
    logic signed [31:0]    p1_z_reg;

    logic accept;
    logic out_free;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free = !rsp_valid_reg || rsp.ready;

    // vertex differences
    logic signed [15:0] ax, ay, bx, by, cx, cy;
    logic signed [17:0] dxba, dyba, dyca, dxca, dycb, dxcb, dyac, dxac;
    assign ax = item_reg.vertex_a_x;
    assign ay = item_reg.vertex_a_y;
    assign bx = item_reg.vertex_b_x;
    assign by = item_reg.vertex_b_y;
    assign cx = item_reg.vertex_c_x;
    assign cy = item_reg.vertex_c_y;
    assign dxba = 18'(bx) - 18'(ax);
    assign dyba = 18'(by) - 18'(ay);
    assign dyca = 18'(cy) - 18'(ay);
    assign dxca = 18'(cx) - 18'(ax);
    assign dycb = 18'(cy) - 18'(by);
    assign dxcb = 18'(cx) - 18'(bx);
    assign dyac = 18'(ay) - 18'(cy);
    assign dxac = 18'(ax) - 18'(cx);

    // first pixel centre of the clipped box
    logic signed [CW-1:0] px0, py0;
    assign px0 = $signed(CW'(x0_reg) << SB) + PX_HALF;
    assign py0 = $signed(CW'(y0_reg) << SB) + PX_HALF;

    // edge steps per pixel
    logic signed [EW-1:0] sx0, sx1, sx2, sy0, sy1, sy2;
    assign sx0 = EW'(dycb) <<< SB;
    assign sx1 = EW'(dyac) <<< SB;
    assign sx2 = EW'(dyba) <<< SB;
    assign sy0 = -(EW'(dxcb) <<< SB);
    assign sy1 = -(EW'(dxac) <<< SB);
    assign sy2 = -(EW'(dxba) <<< SB);

    // operand select for the setup sequence
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic                  step_first;
    logic                  step_neg;
    always_comb
    begin
        mul_a      = '0;
        mul_b      = '0;
        step_first = 1'b0;
        step_neg   = 1'b0;
        unique case (step_reg)
            5'd0:  begin mul_a = MAW'(dxba); mul_b = MBW'(dyca); step_first = 1'b1; end
            5'd1:  begin mul_a = MAW'(dyba); mul_b = MBW'(dxca); step_neg = 1'b1; end
            5'd2:  begin mul_a = MAW'(dycb); mul_b = MBW'(px0 - CW'(bx)); step_first = 1'b1; end
            5'd3:  begin mul_a = MAW'(dxcb); mul_b = MBW'(py0 - CW'(by)); step_neg = 1'b1; end
            5'd4:  begin mul_a = MAW'(dyac); mul_b = MBW'(px0 - CW'(cx)); step_first = 1'b1; end
            5'd5:  begin mul_a = MAW'(dxac); mul_b = MBW'(py0 - CW'(cy)); step_neg = 1'b1; end
            5'd6:  begin mul_a = MAW'(dyba); mul_b = MBW'(px0 - CW'(ax)); step_first = 1'b1; end
            5'd7:  begin mul_a = MAW'(dxba); mul_b = MBW'(py0 - CW'(ay)); step_neg = 1'b1; end
            5'd8:  begin mul_a = e0_reg; mul_b = item_reg.vertex_a_invw; step_first = 1'b1; end
            5'd9:  begin mul_a = e1_reg; mul_b = item_reg.vertex_b_invw; end
            5'd10: begin mul_a = e2_reg; mul_b = item_reg.vertex_c_invw; end
            5'd11: begin mul_a = sx0; mul_b = item_reg.vertex_a_invw; step_first = 1'b1; end
            5'd12: begin mul_a = sx1; mul_b = item_reg.vertex_b_invw; end
            5'd13: begin mul_a = sx2; mul_b = item_reg.vertex_c_invw; end
            5'd14: begin mul_a = sy0; mul_b = item_reg.vertex_a_invw; step_first = 1'b1; end
            5'd15: begin mul_a = sy1; mul_b = item_reg.vertex_b_invw; end
            5'd16: begin mul_a = sy2; mul_b = item_reg.vertex_c_invw; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // shared multiplier and divider
    logic                 mul_done;
    logic signed [PW-1:0] mul_p;
    logic                 div_done;
    logic signed [31:0]   div_q;
    logic signed [PW-1:0] acc_next;

    rtri_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_MULGO),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    rtri_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DIVGO),
        .num   (acc_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    assign acc_next = (step_first ? '0 : acc_reg) + (step_neg ? -mul_p : mul_p);

    // bounding box and clip
    logic signed [15:0] minx, maxx, miny, maxy;
    logic signed [16:0] bx0, bx1, by0, by1;
    logic               off_screen;
    always_comb
    begin
        minx = ax;
        maxx = ax;
        miny = ay;
        maxy = ay;
        if (bx < minx) minx = bx;
        if (cx < minx) minx = cx;
        if (bx > maxx) maxx = bx;
        if (cx > maxx) maxx = cx;
        if (by < miny) miny = by;
        if (cy < miny) miny = cy;
        if (by > maxy) maxy = by;
        if (cy > maxy) maxy = cy;
        bx0 = 17'(minx >>> SB);
        bx1 = 17'(maxx >>> SB);
        by0 = 17'(miny >>> SB);
        by1 = 17'(maxy >>> SB);
        if (bx0 < 0) bx0 = '0;
        if (by0 < 0) by0 = '0;
        if (bx1 > X_LIM) bx1 = X_LIM;
        if (by1 > Y_LIM) by1 = Y_LIM;
        off_screen = (bx0 > bx1) || (by0 > by1);
    end

    // read command addressing
    logic [IXW-1:0] rd_idx;
    logic           rd_in_range;
    logic [AW-1:0]  rd_addr;
    assign rd_idx      = IXW'(item_reg.pixel_index);
    assign rd_in_range = rd_idx < IXW'(rtri_pkg::NPIX);
    assign rd_addr     = rd_idx[AW-1:0];

    // pixel coverage and depth
    logic               covered;
    logic signed [31:0] z_sat;
    assign covered = !ecur0_reg[EW-1] && !ecur1_reg[EW-1] && !ecur2_reg[EW-1];
    always_comb
    begin
        if (zcur_reg > Z_MAX)
        begin
            z_sat = 32'sh7FFFFFFF;
        end
        else if (zcur_reg < Z_MIN)
        begin
            z_sat = 32'sh80000000;
        end
        else
        begin
            z_sat = zcur_reg[31:0];
        end
    end

    // stores
    logic [31:0]   depth_rdata, color_rdata;
    logic          depth_win;
    logic          clearing;
    logic          store_we;
    logic [AW-1:0] store_waddr;
    logic [AW-1:0] depth_raddr;

    assign depth_win   = p1_valid_reg && (p1_z_reg > $signed(depth_rdata));
    assign clearing    = (state_reg == S_CLEAR);
    assign store_we    = clearing || depth_win;
    assign store_waddr = clearing ? clr_addr_reg : p1_addr_reg;
    assign depth_raddr = (state_reg == S_PIX) ? pix_addr_reg : rd_addr;

    rtri_ram #(.WIDTH(32), .DEPTH(rtri_pkg::NPIX)) u_depth_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (clearing ? 32'd0 : p1_z_reg),
        .raddr (depth_raddr),
        .rdata (depth_rdata)
    );

    rtri_ram #(.WIDTH(32), .DEPTH(rtri_pkg::NPIX)) u_color_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (item_reg.color_value),
        .raddr (rd_addr),
        .rdata (color_rdata)
    );

    // command sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            item_reg       <= '0;
            res_status_reg <= rtri_pkg::RES_DONE;
            count_reg      <= '0;
            res_color_reg  <= '0;
            res_depth_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_data_reg   <= '0;
            clr_addr_reg   <= '0;
            acc_reg        <= '0;
            den_reg        <= '0;
            e0_reg         <= '0;
            e1_reg         <= '0;
            e2_reg         <= '0;
            zr_reg         <= '0;
            zx_reg         <= '0;
            zy_reg         <= '0;
            x0_reg         <= '0;
            x1_reg         <= '0;
            y0_reg         <= '0;
            y1_reg         <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            ecur0_reg      <= '0;
            ecur1_reg      <= '0;
            ecur2_reg      <= '0;
            erow0_reg      <= '0;
            erow1_reg      <= '0;
            erow2_reg      <= '0;
            zcur_reg       <= '0;
            zrow_reg       <= '0;
            row_addr_reg   <= '0;
            pix_addr_reg   <= '0;
            p1_valid_reg   <= 1'b0;
            p1_addr_reg    <= '0;
            p1_z_reg       <= '0;
        end
        else
        begin
            p1_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg       <= req.data;
                        res_status_reg <= rtri_pkg::RES_DONE;
                        count_reg      <= '0;
                        res_color_reg  <= '0;
                        res_depth_reg  <= '0;
                        step_reg       <= '0;
                        clr_addr_reg   <= '0;
                        unique case (req.data.cmd)
                            rtri_pkg::CMD_CLEAR: state_reg <= S_CLEAR;
                            rtri_pkg::CMD_DRAW:  state_reg <= S_MULGO;
                            rtri_pkg::CMD_READ:  state_reg <= S_RDADDR;
                            default:             state_reg <= S_FIN;
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == CLR_LAST)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_RDADDR:
                begin
                    state_reg <= rd_in_range ? S_RDDATA : S_FIN;
                end
                S_RDDATA:
                begin
                    res_color_reg <= color_rdata;
                    res_depth_reg <= depth_rdata;
                    state_reg     <= S_FIN;
                end
                S_MULGO:
                begin
                    state_reg <= S_MULWAIT;
                end
                S_MULWAIT:
                begin
                    if (mul_done)
                    begin
                        acc_reg <= acc_next;
                        if (step_reg == STEP_E0_END) e0_reg <= EW'(acc_next);
                        if (step_reg == STEP_E1_END) e1_reg <= EW'(acc_next);
                        if (step_reg == STEP_E2_END) e2_reg <= EW'(acc_next);
                        if (step_reg == STEP_AREA_END)
                        begin
                            state_reg <= S_CULL;
                        end
                        else if (step_reg == STEP_ZR_END || step_reg == STEP_ZX_END
                                 || step_reg == STEP_ZY_END)
                        begin
                            state_reg <= S_DIVGO;
                        end
                        else
                        begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= S_MULGO;
                        end
                    end
                end
                S_CULL:
                begin
                    if (acc_reg >= CULL_LIM)
                    begin
                        res_status_reg <= rtri_pkg::RES_CULLED;
                        state_reg      <= S_FIN;
                    end
                    else if (off_screen)
                    begin
                        res_status_reg <= rtri_pkg::RES_OFFSCREEN;
                        state_reg      <= S_FIN;
                    end
                    else
                    begin
                        den_reg   <= rtri_pkg::DEN_W'(-acc_reg);
                        x0_reg    <= bx0[XW-1:0];
                        x1_reg    <= bx1[XW-1:0];
                        y0_reg    <= by0[YW-1:0];
                        y1_reg    <= by1[YW-1:0];
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= S_MULGO;
                    end
                end
                S_DIVGO:
                begin
                    state_reg <= S_DIVWAIT;
                end
                S_DIVWAIT:
                begin
                    if (div_done)
                    begin
                        if (step_reg == STEP_ZR_END) zr_reg <= div_q;
                        if (step_reg == STEP_ZX_END) zx_reg <= div_q;
                        if (step_reg == STEP_ZY_END) zy_reg <= div_q;
                        if (step_reg == STEP_ZY_END)
                        begin
                            state_reg <= S_PIXINIT;
                        end
                        else
                        begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= S_MULGO;
                        end
                    end
                end
                S_PIXINIT:
                begin
                    x_reg        <= x0_reg;
                    y_reg        <= y0_reg;
                    ecur0_reg    <= e0_reg;
                    ecur1_reg    <= e1_reg;
                    ecur2_reg    <= e2_reg;
                    erow0_reg    <= e0_reg;
                    erow1_reg    <= e1_reg;
                    erow2_reg    <= e2_reg;
                    zcur_reg     <= ZW'(zr_reg);
                    zrow_reg     <= ZW'(zr_reg);
                    row_addr_reg <= AW'(y0_reg) * ROW_STEP + AW'(x0_reg);
                    pix_addr_reg <= AW'(y0_reg) * ROW_STEP + AW'(x0_reg);
                    state_reg    <= S_PIX;
                end
                S_PIX:
                begin
                    // issue depth read for this pixel, test lands next cycle
                    p1_valid_reg <= covered;
                    p1_addr_reg  <= pix_addr_reg;
                    p1_z_reg     <= z_sat;
                    if (x_reg == x1_reg)
                    begin
                        if (y_reg == y1_reg)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            y_reg        <= y_reg + 1'b1;
                            x_reg        <= x0_reg;
                            erow0_reg    <= erow0_reg + sy0;
                            erow1_reg    <= erow1_reg + sy1;
                            erow2_reg    <= erow2_reg + sy2;
                            ecur0_reg    <= erow0_reg + sy0;
                            ecur1_reg    <= erow1_reg + sy1;
                            ecur2_reg    <= erow2_reg + sy2;
                            zrow_reg     <= zrow_reg + ZW'(zy_reg);
                            zcur_reg     <= zrow_reg + ZW'(zy_reg);
                            row_addr_reg <= row_addr_reg + ROW_STEP;
                            pix_addr_reg <= row_addr_reg + ROW_STEP;
                        end
                    end
                    else
                    begin
                        x_reg        <= x_reg + 1'b1;
                        ecur0_reg    <= ecur0_reg + sx0;
                        ecur1_reg    <= ecur1_reg + sx1;
                        ecur2_reg    <= ecur2_reg + sx2;
                        zcur_reg     <= zcur_reg + ZW'(zx_reg);
                        pix_addr_reg <= pix_addr_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    res_status_reg <= rtri_pkg::RES_DRAWN;
                    state_reg      <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // count pixels that won the depth test
            if (depth_win)
            begin
                count_reg <= count_reg + 1'b1;
            end

            // output register
            if (state_reg == S_FIN && out_free)
            begin
                rsp_valid_reg               <= 1'b1;
                rsp_data_reg.status         <= res_status_reg;
                rsp_data_reg.pixels_written <= count_reg;
                rsp_data_reg.read_color     <= res_color_reg;
                rsp_data_reg.read_depth     <= $signed(res_depth_reg);
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // the depth write of one pixel never meets the read of the next
    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PIX && p1_valid_reg) |-> (pix_addr_reg != p1_addr_reg))
        else $error("depth read and write hit the same entry");

    // no pixel write is pending while the clear sweep owns the write port
    a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !p1_valid_reg)
        else $error("pixel write pending during clear");

    // a new result only comes from the finish state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result raised outside finish state");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for triangle_raster_depth_test. Commands go in on the
// req channel and an in-bench rasterizer with its own depth and colour stores
// predicts every result; each result transaction is checked field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         ONE        = 1 << rtri_pkg::SUB_BITS;
    localparam longint     CYCLE_CAP  = 20000000;
    localparam int         RANDOM_ITEMS = 400;

    logic clk = 1'b0;
    logic rst_n;

    rtri_req_if req_ch ();
    rtri_rsp_if rsp_ch ();

    triangle_raster_depth_test dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predicted screen contents
    logic [31:0] depth_mem [rtri_pkg::NPIX];
    logic [31:0] color_mem [rtri_pkg::NPIX];

    rtri_pkg::rsp_t pending_q [$];
    int     error_count = 0;
    longint cycle_count = 0;
    bit     quiet;
    int     n_clear, n_draw, n_read, n_odd;
    int     n_drawn, n_culled, n_offscreen;
    longint n_pixels;

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic longint edge_val(longint ux, longint uy, longint vx,
                                        longint vy, longint px, longint py);
        return (vy - uy) * (px - ux) - (vx - ux) * (py - uy);
    endfunction

    function automatic logic signed [79:0] wide_mul(longint a, longint b);
        logic signed [79:0] wa;
        logic signed [79:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    // quotient toward zero, clamped to the signed 32-bit range
    function automatic longint plane_quotient(logic signed [79:0] n, longint d);
        logic [79:0] mag;
        logic [79:0] den;
        logic [79:0] q;
        bit          neg;
        neg = n[79];
        mag = neg ? -n : n;
        den = d;
        if (mag >= (den << 31))
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        q = mag / den;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic rtri_pkg::rsp_t raster_predict(rtri_pkg::req_t r);
        rtri_pkg::rsp_t res;
        longint ax, ay, bx, by, cx, cy, aw, bw, cw;
        longint area, minx, maxx, miny, maxy, x0, x1, y0, y1, px, py;
        longint zr, zx, zy, z;
        longint written;
        logic signed [79:0] acc;
        int     idx;
        res = '0;
        ax = r.vertex_a_x; ay = r.vertex_a_y; aw = r.vertex_a_invw;
        bx = r.vertex_b_x; by = r.vertex_b_y; bw = r.vertex_b_invw;
        cx = r.vertex_c_x; cy = r.vertex_c_y; cw = r.vertex_c_invw;
        written = 0;
        case (r.cmd)
            rtri_pkg::CMD_CLEAR:
            begin
                for (int i = 0; i < rtri_pkg::NPIX; i++)
                begin
                    color_mem[i] = r.color_value;
                    depth_mem[i] = '0;
                end
                res.status = rtri_pkg::RES_DONE;
            end
            rtri_pkg::CMD_READ:
            begin
                res.status = rtri_pkg::RES_DONE;
                if (r.pixel_index < rtri_pkg::NPIX)
                begin
                    res.read_color = color_mem[r.pixel_index];
                    res.read_depth = depth_mem[r.pixel_index];
                end
            end
            rtri_pkg::CMD_DRAW:
            begin
                area = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
                if (area >= -(ONE * ONE))
                begin
                    res.status = rtri_pkg::RES_CULLED;
                    return res;
                end
                area = -area;
                minx = ax; maxx = ax; miny = ay; maxy = ay;
                if (bx < minx) minx = bx;
                if (cx < minx) minx = cx;
                if (bx > maxx) maxx = bx;
                if (cx > maxx) maxx = cx;
                if (by < miny) miny = by;
                if (cy < miny) miny = cy;
                if (by > maxy) maxy = by;
                if (cy > maxy) maxy = cy;
                x0 = minx >>> rtri_pkg::SUB_BITS;
                x1 = maxx >>> rtri_pkg::SUB_BITS;
                y0 = miny >>> rtri_pkg::SUB_BITS;
                y1 = maxy >>> rtri_pkg::SUB_BITS;
                if (x0 < 0) x0 = 0;
                if (y0 < 0) y0 = 0;
                if (x1 > rtri_pkg::FB_WIDTH - 1) x1 = rtri_pkg::FB_WIDTH - 1;
                if (y1 > rtri_pkg::FB_HEIGHT - 1) y1 = rtri_pkg::FB_HEIGHT - 1;
                if (x0 > x1 || y0 > y1)
                begin
                    res.status = rtri_pkg::RES_OFFSCREEN;
                    return res;
                end
                // depth plane at the box corner and its per-pixel steps
                px = x0 * ONE + ONE / 2;
                py = y0 * ONE + ONE / 2;
                acc = wide_mul(edge_val(bx, by, cx, cy, px, py), aw)
                    + wide_mul(edge_val(cx, cy, ax, ay, px, py), bw)
                    + wide_mul(edge_val(ax, ay, bx, by, px, py), cw);
                zr = plane_quotient(acc, area);
                acc = wide_mul((cy - by) * ONE, aw) + wide_mul((ay - cy) * ONE, bw)
                    + wide_mul((by - ay) * ONE, cw);
                zx = plane_quotient(acc, area);
                acc = wide_mul(-(cx - bx) * ONE, aw) + wide_mul(-(ax - cx) * ONE, bw)
                    + wide_mul(-(bx - ax) * ONE, cw);
                zy = plane_quotient(acc, area);
                // walk the clipped box
                for (longint y = y0; y <= y1; y++)
                begin
                    py = y * ONE + ONE / 2;
                    for (longint x = x0; x <= x1; x++)
                    begin
                        px = x * ONE + ONE / 2;
                        if (edge_val(bx, by, cx, cy, px, py) >= 0 &&
                            edge_val(cx, cy, ax, ay, px, py) >= 0 &&
                            edge_val(ax, ay, bx, by, px, py) >= 0)
                        begin
                            idx = int'(y * rtri_pkg::FB_WIDTH + x);
                            z = clamp32(zr + zx * (x - x0) + zy * (y - y0));
                            if (z > longint'($signed(depth_mem[idx])))
                            begin
                                depth_mem[idx] = z[31:0];
                                color_mem[idx] = r.color_value;
                                written++;
                            end
                        end
                    end
                end
                res.status = rtri_pkg::RES_DRAWN;
                res.pixels_written = written[14:0];
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR @%0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        rtri_pkg::rsp_t got;
        rtri_pkg::rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (pending_q.size() == 0)
                report_mismatch("unexpected result transaction status", got.status, 0);
            else
            begin
                want = pending_q.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.pixels_written != want.pixels_written)
                    report_mismatch("pixels_written", got.pixels_written,
                                    want.pixels_written);
                if (got.read_color != want.read_color)
                    report_mismatch("read_color", got.read_color, want.read_color);
                if (got.read_depth != want.read_depth)
                    report_mismatch("read_depth", got.read_depth, want.read_depth);
                case (want.status)
                    rtri_pkg::RES_DRAWN:     n_drawn++;
                    rtri_pkg::RES_CULLED:    n_culled++;
                    rtri_pkg::RES_OFFSCREEN: n_offscreen++;
                    default:       ;
                endcase
                n_pixels += want.pixels_written;
            end
        end
    end

    // result side back-pressure in random bursts, with calm windows
    always @(posedge clk)
    begin
        static int stall_left = 0;
        static int calm_left  = 0;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (quiet || calm_left > 0)
        begin
            if (calm_left > 0)
                calm_left--;
            rsp_ch.ready <= 1'b1;
        end
        else if ($urandom_range(0, 199) == 0)
        begin
            calm_left = $urandom_range(200, 2000);
            rsp_ch.ready <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("triangle_raster_depth_test: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // send one command transaction and predict its result on acceptance
    task automatic send_command(rtri_pkg::req_t item);
        int gap;
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_q.push_back(raster_predict(item));
        case (item.cmd)
            rtri_pkg::CMD_CLEAR: n_clear++;
            rtri_pkg::CMD_DRAW:  n_draw++;
            rtri_pkg::CMD_READ:  n_read++;
            default:   n_odd++;
        endcase
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic rtri_pkg::req_t make_triangle(int ax, int ay, int bx, int by,
                                                     int cx, int cy, logic [31:0] aw,
                                                     logic [31:0] bw, logic [31:0] cw,
                                                     logic [31:0] color);
        rtri_pkg::req_t t;
        t = '0;
        t.cmd = rtri_pkg::CMD_DRAW;
        t.vertex_a_x = ax[15:0]; t.vertex_a_y = ay[15:0]; t.vertex_a_invw = aw;
        t.vertex_b_x = bx[15:0]; t.vertex_b_y = by[15:0]; t.vertex_b_invw = bw;
        t.vertex_c_x = cx[15:0]; t.vertex_c_y = cy[15:0]; t.vertex_c_invw = cw;
        t.color_value = color;
        return t;
    endfunction

    function automatic rtri_pkg::req_t make_simple(logic [1:0] cmd, logic [31:0] color,
                                                   logic [13:0] pix);
        rtri_pkg::req_t t;
        t = '0;
        t.cmd = cmd;
        t.color_value = color;
        t.pixel_index = pix;
        return t;
    endfunction

    // small triangle near the screen, mostly front facing
    function automatic rtri_pkg::req_t random_small_triangle();
        rtri_pkg::req_t t;
        int   base_x, base_y, reach, tmp;
        logic [15:0] sx, sy;
        base_x = $urandom_range(0, 2400) - 200;
        base_y = $urandom_range(0, 2400) - 200;
        reach  = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 900)
                                               : $urandom_range(8, 180);
        t = make_triangle(base_x + $urandom_range(0, 2 * reach) - reach,
                          base_y + $urandom_range(0, 2 * reach) - reach,
                          base_x + $urandom_range(0, 2 * reach) - reach,
                          base_y + $urandom_range(0, 2 * reach) - reach,
                          base_x + $urandom_range(0, 2 * reach) - reach,
                          base_y + $urandom_range(0, 2 * reach) - reach,
                          $urandom_range(1 << 20, 1 << 30), $urandom_range(1 << 20, 1 << 30),
                          $urandom_range(1 << 20, 1 << 30), $urandom());
        if ($urandom_range(0, 4) == 0)
        begin
            t.vertex_a_invw = $urandom();
            t.vertex_b_invw = $urandom();
            t.vertex_c_invw = $urandom();
        end
        tmp = (t.vertex_b_x - t.vertex_a_x) * (t.vertex_c_y - t.vertex_a_y)
            - (t.vertex_b_y - t.vertex_a_y) * (t.vertex_c_x - t.vertex_a_x);
        if (tmp > 0 && $urandom_range(0, 9) != 0)
        begin
            sx = t.vertex_b_x; sy = t.vertex_b_y;
            t.vertex_b_x = t.vertex_c_x; t.vertex_b_y = t.vertex_c_y;
            t.vertex_c_x = sx; t.vertex_c_y = sy;
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_clear_and_read();
        send_command(make_simple(rtri_pkg::CMD_CLEAR, 32'h0000_0000, '0));
        send_command(make_simple(rtri_pkg::CMD_READ, '0, 14'd0));
        send_command(make_simple(rtri_pkg::CMD_READ, '0, 14'(rtri_pkg::NPIX - 1)));
        send_command(make_simple(rtri_pkg::CMD_CLEAR, 32'hFFFF_FFFF, '0));
        send_command(make_simple(rtri_pkg::CMD_READ, '0, 14'd8256));
        send_command(make_simple(CMD_UNUSED, $urandom(), 14'h3FFF));
    endtask

    task automatic test_directed_triangles();
        // front facing, then the same triangle wound the other way
        send_command(make_triangle(16, 16, 16, 80, 80, 16, 32'h2000_0000,
                                   32'h1000_0000, 32'h0800_0000, 32'h1234_5678));
        send_command(make_triangle(16, 16, 80, 16, 16, 80, 32'h2000_0000,
                                   32'h1000_0000, 32'h0800_0000, 32'h1234_5678));
        // sliver right at the cull threshold, one just past it, and a line
        send_command(make_triangle(0, 0, 0, 16, 16, 0, 32'h4000_0000,
                                   32'h4000_0000, 32'h4000_0000, 32'hA5A5_A5A5));
        send_command(make_triangle(0, 0, 0, 16, 17, 0, 32'h4000_0000,
                                   32'h4000_0000, 32'h4000_0000, 32'hA5A5_A5A5));
        send_command(make_triangle(0, 0, 64, 64, 128, 128, 32'h4000_0000,
                                   32'h4000_0000, 32'h4000_0000, 32'h0));
        // box entirely off screen, once below zero and once past the far edges
        send_command(make_triangle(-500, -500, -500, -400, -400, -500, 32'h1,
                                   32'h1, 32'h1, 32'h5));
        send_command(make_triangle(3000, 3000, 3000, 3100, 3100, 3000, 32'h1,
                                   32'h1, 32'h1, 32'h5));
        // extreme vertices covering the screen, depth saturating high
        send_command(make_triangle(-32768, -32768, -32768, 32767, 32767, -32768,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'hFFFF_FFFF));
        send_command(make_simple(rtri_pkg::CMD_READ, '0, 14'd0));
        // negative depth loses against far
        send_command(make_simple(rtri_pkg::CMD_CLEAR, 32'h00C0_FFEE, '0));
        send_command(make_triangle(-32768, -32768, -32768, 32767, 32767, -32768,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h0));
        // mixed extreme depths, saturating steps
        send_command(make_triangle(-32768, 0, 0, 2047, 2047, -32768, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'h55AA_55AA));
        send_command(make_simple(rtri_pkg::CMD_READ, '0, 14'd4160));
        send_command(make_simple(rtri_pkg::CMD_READ, '0, 14'(rtri_pkg::NPIX - 1)));
        send_command(make_simple(CMD_UNUSED, '0, '0));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int   pick;
        rtri_pkg::req_t t;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            if (i == RANDOM_ITEMS - 60)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                t = random_small_triangle();
            else if (pick < 60)
            begin
                // raw vertices, all bits loose
                t = make_triangle($urandom(), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom());
            end
            else if (pick < 88)
                t = make_simple(rtri_pkg::CMD_READ, $urandom(),
                                14'($urandom_range(0, rtri_pkg::NPIX - 1)));
            else if (pick < 93)
                t = make_simple(CMD_UNUSED, $urandom(), 14'($urandom()));
            else if (pick < 95)
                t = make_simple(rtri_pkg::CMD_CLEAR, $urandom(), 14'($urandom()));
            else
            begin
                t = random_small_triangle();
                t.cmd = rtri_pkg::CMD_READ;
                t.pixel_index = 14'($urandom());
            end
            send_command(t);
        end
        req_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        quiet        = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_clear_and_read();
        test_directed_triangles();
        test_random_traffic();

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d clears, %0d draws, %0d reads, %0d unknown commands",
                 n_clear, n_draw, n_read, n_odd);
        $display("draws: %0d drawn (%0d pixels), %0d culled, %0d off screen",
                 n_drawn, n_pixels, n_culled, n_offscreen);
        if (error_count == 0)
            $display("triangle_raster_depth_test: match");
        else
            $display("triangle_raster_depth_test: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rtri_pkg.sv
rtl/rtri_if.sv
rtl/rtri_ram.sv
rtl/rtri_mul.sv
rtl/rtri_div.sv
rtl/triangle_raster_depth_test.sv
tb/testbench.sv
